FILE: rtl/pli_pkg.sv
// shared types and constants of the piecewise linear interpolator
// no dependencies; used by every module under rtl
package pli_pkg;

    localparam int DATA_WIDTH     = 32;
    localparam int MAX_POINTS_DEF = 256;
    localparam int NUM_W          = 9;
    localparam int IDX_W          = 8;
    localparam int CFG_IDX_W      = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_BLANKING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANKING_VALUE = 2'd2;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // region codes
    localparam logic [1:0] REGION_INSIDE = 2'd0;
    localparam logic [1:0] REGION_BELOW  = 2'd1;
    localparam logic [1:0] REGION_ABOVE  = 2'd2;

    typedef struct packed {
        logic                         cmd;
        logic [IDX_W-1:0]             point_index;
        logic signed [DATA_WIDTH-1:0] x_value;
        logic signed [DATA_WIDTH-1:0] y_value;
        logic                         first_of_batch;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] interp_y;
        logic [1:0]                   region;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LAST,
        ST_CHECK,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_SEG_B,
        ST_DIFF,
        ST_MUL,
        ST_DIV,
        ST_SAT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_LATCH_FIRST,
        OP_OUT_BELOW,
        OP_OUT_ABOVE,
        OP_STEP,
        OP_LATCH_SEG,
        OP_DIFF,
        OP_MUL,
        OP_DIV,
        OP_OUT_FLAT,
        OP_OUT_INTERP
    } t_dp_op;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_LAST,
        RD_NEXT,
        RD_SEG
    } t_rd_sel;

    typedef struct packed {
        t_dp_op  op;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic below;
        logic above;
        logic can_step;
        logic step_gt;
        logic dx_zero;
        logic div_last;
    } t_dp_status;

endpackage

FILE: rtl/pli_ctrl.sv
// control state machine of the interpolator: sequences reads, search,
// multiply and serial divide; depends on pli_pkg
module pli_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_cmd,
    input  pli_pkg::t_dp_status i_status,
    output pli_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy
);

    pli_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pli_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pli_pkg::ST_IDLE: begin
                if (i_start && i_cmd == pli_pkg::CMD_QUERY) n_state = pli_pkg::ST_RD_LAST;
            end
            pli_pkg::ST_RD_LAST: n_state = pli_pkg::ST_CHECK;
            pli_pkg::ST_CHECK: begin
                if (i_status.below || i_status.above) n_state = pli_pkg::ST_IDLE;
                else n_state = pli_pkg::ST_WALK_RD;
            end
            pli_pkg::ST_WALK_RD: begin
                if (i_status.can_step) n_state = pli_pkg::ST_WALK_CMP;
                else n_state = pli_pkg::ST_SEG_B;
            end
            pli_pkg::ST_WALK_CMP: begin
                if (i_status.step_gt) n_state = pli_pkg::ST_WALK_RD;
                else n_state = pli_pkg::ST_SEG_B;
            end
            pli_pkg::ST_SEG_B: n_state = pli_pkg::ST_DIFF;
            pli_pkg::ST_DIFF:  n_state = pli_pkg::ST_MUL;
            pli_pkg::ST_MUL: begin
                if (i_status.dx_zero) n_state = pli_pkg::ST_IDLE;
                else n_state = pli_pkg::ST_DIV;
            end
            pli_pkg::ST_DIV: begin
                if (i_status.div_last) n_state = pli_pkg::ST_SAT;
            end
            pli_pkg::ST_SAT: n_state = pli_pkg::ST_IDLE;
            default: n_state = pli_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op     = pli_pkg::OP_NONE;
        o_cmd.rd_sel = pli_pkg::RD_ZERO;
        o_busy       = 1'b1;
        case (r_state)
            pli_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_cmd == pli_pkg::CMD_QUERY) o_cmd.op = pli_pkg::OP_START;
                    else o_cmd.op = pli_pkg::OP_LOAD;
                end
            end
            pli_pkg::ST_RD_LAST: begin
                o_cmd.op     = pli_pkg::OP_LATCH_FIRST;
                o_cmd.rd_sel = pli_pkg::RD_LAST;
            end
            pli_pkg::ST_CHECK: begin
                if (i_status.below) o_cmd.op = pli_pkg::OP_OUT_BELOW;
                else if (i_status.above) o_cmd.op = pli_pkg::OP_OUT_ABOVE;
            end
            pli_pkg::ST_WALK_RD: begin
                o_cmd.rd_sel = i_status.can_step ? pli_pkg::RD_NEXT : pli_pkg::RD_SEG;
            end
            pli_pkg::ST_WALK_CMP: begin
                if (i_status.step_gt) o_cmd.op = pli_pkg::OP_STEP;
                else o_cmd.rd_sel = pli_pkg::RD_SEG;
            end
            pli_pkg::ST_SEG_B: begin
                o_cmd.op     = pli_pkg::OP_LATCH_SEG;
                o_cmd.rd_sel = pli_pkg::RD_NEXT;
            end
            pli_pkg::ST_DIFF: o_cmd.op = pli_pkg::OP_DIFF;
            pli_pkg::ST_MUL: begin
                o_cmd.op = i_status.dx_zero ? pli_pkg::OP_OUT_FLAT : pli_pkg::OP_MUL;
            end
            pli_pkg::ST_DIV: o_cmd.op = pli_pkg::OP_DIV;
            pli_pkg::ST_SAT: o_cmd.op = pli_pkg::OP_OUT_INTERP;
            default: o_cmd.op = pli_pkg::OP_NONE;
        endcase
    end

endmodule

FILE: rtl/pli_datapath.sv
// datapath of the interpolator: point tables, config registers, segment
// pointer, multiplier, serial divider and saturation; depends on pli_pkg
module pli_datapath #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pli_pkg::t_in_item                 i_item,
    input  pli_pkg::t_dp_cmd                  i_cmd,
    input  logic                              i_cfg_we,
    input  logic [pli_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pli_pkg::DATA_WIDTH-1:0]    i_cfg_data,
    output pli_pkg::t_dp_status               o_status,
    output logic                              o_result_valid,
    output pli_pkg::t_out_item                o_result
);

    localparam int DW = pli_pkg::DATA_WIDTH;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int PW = 2 * (DW + 1);
    localparam int CW = $clog2(PW + 1);
    localparam logic [DW:0] HALF = (DW + 1)'(1) << (DW - 1);
    localparam logic signed [DW-1:0] Y_MAX = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0] Y_MIN = {1'b1, {(DW - 1){1'b0}}};

    logic signed [DW-1:0] mem_x [MAX_POINTS];
    logic signed [DW-1:0] mem_y [MAX_POINTS];

    logic [pli_pkg::NUM_W-1:0] r_num_points;
    logic                      r_use_blank;
    logic signed [DW-1:0]      r_blank;

    logic signed [DW-1:0] r_rd_x, r_rd_y;
    logic signed [DW-1:0] r_xq, r_fx, r_fy, r_x0, r_y0;
    logic [NW-1:0]        r_n;
    logic [AW-1:0]        r_seg;
    logic [DW:0]          r_mdx, r_mdy, r_mt;
    logic                 r_neg, r_dx_zero;
    logic [PW-1:0]        r_prod, r_quo;
    logic [DW:0]          r_rem;
    logic [CW-1:0]        r_cnt;
    logic                 r_valid;
    pli_pkg::t_out_item   r_out;

    logic [AW-1:0] rd_addr;
    logic [31:0]   n_raw, n_cl, seg_base, seg_lim, idx32;
    logic signed [DW:0] dx, dy, t;
    logic [DW+1:0] rem_sh, rem_sub;
    logic          rem_ge;
    logic [DW:0]   y0e, lim;
    logic          sat;
    logic signed [DW-1:0] interp;

    always_comb begin
        case (i_cmd.rd_sel)
            pli_pkg::RD_ZERO: rd_addr = '0;
            pli_pkg::RD_LAST: rd_addr = AW'(32'(r_n) - 32'd1);
            pli_pkg::RD_NEXT: rd_addr = r_seg + AW'(1);
            pli_pkg::RD_SEG:  rd_addr = r_seg;
            default:          rd_addr = '0;
        endcase
    end

    assign idx32 = 32'(i_item.point_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pli_pkg::OP_LOAD && idx32 < 32'(MAX_POINTS)) begin
            mem_x[idx32[AW-1:0]] <= i_item.x_value;
            mem_y[idx32[AW-1:0]] <= i_item.y_value;
        end
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= pli_pkg::NUM_W'(2);
            r_use_blank  <= 1'b0;
            r_blank      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pli_pkg::CFG_NUM_POINTS:     r_num_points <= i_cfg_data[pli_pkg::NUM_W-1:0];
                pli_pkg::CFG_USE_BLANKING:   r_use_blank  <= i_cfg_data[0];
                pli_pkg::CFG_BLANKING_VALUE: r_blank      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // point count saturated to the table, pointer pulled back into it
    always_comb begin
        n_raw = 32'(r_num_points);
        if (n_raw < 32'd2) n_cl = 32'd2;
        else if (n_raw > 32'(MAX_POINTS)) n_cl = 32'(MAX_POINTS);
        else n_cl = n_raw;
        seg_base = i_item.first_of_batch ? 32'd0 : 32'(r_seg);
        seg_lim  = n_cl - 32'd2;
    end

    assign dx = {r_rd_x[DW-1], r_rd_x} - {r_x0[DW-1], r_x0};
    assign dy = {r_rd_y[DW-1], r_rd_y} - {r_y0[DW-1], r_y0};
    assign t  = {r_xq[DW-1], r_xq} - {r_x0[DW-1], r_x0};

    // restoring divide, one quotient bit a cycle
    assign rem_sh  = {r_rem, r_prod[PW-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_mdx};
    assign rem_sub = rem_sh - {1'b0, r_mdx};

    always_comb begin
        y0e = {r_y0[DW-1], r_y0};
        lim = r_neg ? (y0e + HALF) : ((HALF - (DW + 1)'(1)) - y0e);
        sat = r_quo > PW'(lim);
        if (r_neg) interp = sat ? Y_MIN : (r_y0 - r_quo[DW-1:0]);
        else       interp = sat ? Y_MAX : (r_y0 + r_quo[DW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (i_cmd.op)
                pli_pkg::OP_LOAD: r_seg <= '0;
                pli_pkg::OP_START: begin
                    r_seg <= AW'((seg_base > seg_lim) ? seg_lim : seg_base);
                end
                pli_pkg::OP_STEP: r_seg <= r_seg + AW'(1);
                pli_pkg::OP_OUT_BELOW, pli_pkg::OP_OUT_ABOVE,
                pli_pkg::OP_OUT_FLAT, pli_pkg::OP_OUT_INTERP: r_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pli_pkg::OP_START: begin
                r_xq <= i_item.x_value;
                r_n  <= NW'(n_cl);
            end
            pli_pkg::OP_LATCH_FIRST: begin
                r_fx <= r_rd_x;
                r_fy <= r_rd_y;
            end
            pli_pkg::OP_OUT_BELOW: begin
                r_out.interp_y <= r_use_blank ? r_blank : r_fy;
                r_out.region   <= pli_pkg::REGION_BELOW;
            end
            pli_pkg::OP_OUT_ABOVE: begin
                r_out.interp_y <= r_use_blank ? r_blank : r_rd_y;
                r_out.region   <= pli_pkg::REGION_ABOVE;
            end
            pli_pkg::OP_LATCH_SEG: begin
                r_x0 <= r_rd_x;
                r_y0 <= r_rd_y;
            end
            pli_pkg::OP_DIFF: begin
                r_mdx     <= dx[DW] ? (DW + 1)'(-dx) : dx;
                r_mdy     <= dy[DW] ? (DW + 1)'(-dy) : dy;
                r_mt      <= t[DW] ? (DW + 1)'(-t) : t;
                r_neg     <= (dx[DW] ^ dy[DW]) ^ t[DW];
                r_dx_zero <= dx == '0;
            end
            pli_pkg::OP_MUL: begin
                r_prod <= PW'(r_mdy) * PW'(r_mt);
                r_rem  <= '0;
                r_cnt  <= CW'(PW);
            end
            pli_pkg::OP_DIV: begin
                r_rem  <= rem_ge ? rem_sub[DW:0] : rem_sh[DW:0];
                r_prod <= r_prod << 1;
                r_quo  <= {r_quo[PW-2:0], rem_ge};
                r_cnt  <= r_cnt - CW'(1);
            end
            pli_pkg::OP_OUT_FLAT: begin
                r_out.interp_y <= r_y0;
                r_out.region   <= pli_pkg::REGION_INSIDE;
            end
            pli_pkg::OP_OUT_INTERP: begin
                r_out.interp_y <= interp;
                r_out.region   <= pli_pkg::REGION_INSIDE;
            end
            default: ;
        endcase
    end

    assign o_status.below    = r_xq < r_fx;
    assign o_status.above    = r_xq > r_rd_x;
    assign o_status.can_step = (32'(r_seg) + 32'd1) < (32'(r_n) - 32'd1);
    assign o_status.step_gt  = r_xq > r_rd_x;
    assign o_status.dx_zero  = r_dx_zero;
    assign o_status.div_last = r_cnt == CW'(1);

    assign o_result_valid = r_valid;
    assign o_result       = r_out;

endmodule

FILE: rtl/piecewise_linear_interpolator.sv
// piecewise linear interpolator with end clamp or blanking
// a load is taken in idle without raising busy; a query holds busy while it reads
// the last point, checks range, walks the pointer (one table read per step), multiplies,
// divides one bit per cycle and saturates; out-of-range and zero-width queries end early
// the result strobe lasts one cycle, the first with busy low; the receiver cannot stall it
// synchronous active-low reset clears control and config; tables are not cleared
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pli_pkg::t_in_item              i_cmd_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pli_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pli_pkg::DATA_WIDTH-1:0] i_cfg_data,
    output logic                           o_result_valid,
    output pli_pkg::t_out_item             o_result
);

    pli_pkg::t_dp_cmd    dp_cmd;
    pli_pkg::t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    pli_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd_item.cmd),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    pli_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_cmd_item),
        .i_cmd          (dp_cmd),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_status       (dp_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

FILE: test/piecewise_linear_interpolator_tb.sv
// self-checking testbench for the piecewise linear interpolator
// depends on pli_pkg and piecewise_linear_interpolator under rtl
// directed table of loads, queries and register writes, then random curves and batches
`timescale 1ns / 100ps

module piecewise_linear_interpolator_tb;

    localparam longint Q_MAX       = 64'sd2147483647;
    localparam longint Q_MIN       = -64'sd2147483648;
    localparam int     TABLE_DEPTH = 256;
    localparam int     ITEM_GOAL   = 1350;
    localparam int     CYCLE_LIMIT = 4000000;
    localparam int     DRAIN_WAIT  = 700;

    typedef struct {
        bit                                 is_cfg;
        logic [pli_pkg::CFG_IDX_W-1:0]      cfg_idx;
        logic [pli_pkg::DATA_WIDTH-1:0]     cfg_data;
        pli_pkg::t_in_item                  item;
        bit                                 typed;
        pli_pkg::t_out_item                 want;
    } t_dir_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    pli_pkg::t_in_item              i_cmd_item;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [pli_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [pli_pkg::DATA_WIDTH-1:0] i_cfg_data;
    logic                           o_result_valid;
    pli_pkg::t_out_item             o_result;

    // typed expectation travels with the item beat
    logic               typed_en;
    pli_pkg::t_out_item typed_want;

    // predictor state
    logic signed [pli_pkg::DATA_WIDTH-1:0] curve_x [TABLE_DEPTH];
    logic signed [pli_pkg::DATA_WIDTH-1:0] curve_y [TABLE_DEPTH];
    int                                    seg_ptr;
    logic [pli_pkg::NUM_W-1:0]             num_points;
    logic                                  use_blanking;
    logic signed [pli_pkg::DATA_WIDTH-1:0] blanking_value;

    pli_pkg::t_out_item expected_q[$];
    int        cycles;
    int        items_sent;
    int        queries_checked;
    int        mismatches;
    int        failures;
    bit        quiet;
    t_dir_row  dir_rows[$];

    piecewise_linear_interpolator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd_item     (i_cmd_item),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint abs_l(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // line through segment k evaluated at xq, truncated toward zero, saturated
    function automatic longint segment_value(input int k, input longint xq);
        longint       x0, y0, dx, dy, t, room;
        logic [127:0] prod, quo;
        bit           neg;
        x0 = curve_x[k];
        y0 = curve_y[k];
        dx = longint'(curve_x[k+1]) - x0;
        dy = longint'(curve_y[k+1]) - y0;
        t  = xq - x0;
        if (dx == 0) return y0;
        prod = 128'(abs_l(dy)) * 128'(abs_l(t));
        quo  = prod / 128'(abs_l(dx));
        neg  = ((dx < 0) != (dy < 0)) != (t < 0);
        if (neg) begin
            room = y0 - Q_MIN;
            if (quo > 128'(room)) return Q_MIN;
            return y0 - longint'(quo[63:0]);
        end
        room = Q_MAX - y0;
        if (quo > 128'(room)) return Q_MAX;
        return y0 + longint'(quo[63:0]);
    endfunction

    function automatic int active_points();
        int n;
        n = num_points;
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        return n;
    endfunction

    // advances the predictor by one item; returns 1 when a result follows
    function automatic bit interp_predict(input pli_pkg::t_in_item it,
                                          output pli_pkg::t_out_item res);
        int     n;
        longint xq, val;
        res = '0;
        if (it.cmd == pli_pkg::CMD_LOAD) begin
            curve_x[it.point_index] = it.x_value;
            curve_y[it.point_index] = it.y_value;
            seg_ptr = 0;
            return 1'b0;
        end
        n = active_points();
        if (it.first_of_batch) seg_ptr = 0;
        if (seg_ptr > n - 2) seg_ptr = n - 2;
        xq = it.x_value;
        if (xq < longint'(curve_x[0])) begin
            res.region = pli_pkg::REGION_BELOW;
            val = use_blanking ? longint'(blanking_value) : longint'(curve_y[0]);
        end else if (xq > longint'(curve_x[n-1])) begin
            res.region = pli_pkg::REGION_ABOVE;
            val = use_blanking ? longint'(blanking_value) : longint'(curve_y[n-1]);
        end else begin
            while (seg_ptr + 1 < n - 1 && xq > longint'(curve_x[seg_ptr+1]))
                seg_ptr++;
            res.region = pli_pkg::REGION_INSIDE;
            val = segment_value(seg_ptr, xq);
        end
        res.interp_y = val[pli_pkg::DATA_WIDTH-1:0];
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        pli_pkg::t_out_item pred, got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_q.size());
            $display("tb: failure");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pli_pkg::CFG_NUM_POINTS:
                        num_points = i_cfg_data[pli_pkg::NUM_W-1:0];
                    pli_pkg::CFG_USE_BLANKING:   use_blanking   = i_cfg_data[0];
                    pli_pkg::CFG_BLANKING_VALUE: blanking_value = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_result_valid) begin
                got = o_result;
                if (expected_q.size() == 0) begin
                    failures++;
                    $display("unexpected result y=%h region=%0d", got.interp_y, got.region);
                end else begin
                    pred = expected_q.pop_front();
                    queries_checked++;
                    if (got.interp_y !== pred.interp_y || got.region !== pred.region) begin
                        failures++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want y=%h region=%0d, got y=%h region=%0d",
                                     pred.interp_y, pred.region, got.interp_y, got.region);
                    end
                end
            end
            if (start && !busy) begin
                if (interp_predict(i_cmd_item, pred))
                    expected_q.push_back(typed_en ? typed_want : pred);
            end
        end
    end

    function automatic pli_pkg::t_in_item mk_item(input logic cmd,
                                                  input logic [pli_pkg::IDX_W-1:0] idx,
                                                  input logic [31:0] x, input logic [31:0] y,
                                                  input logic first);
        pli_pkg::t_in_item it;
        it.cmd            = cmd;
        it.point_index    = idx;
        it.x_value        = x;
        it.y_value        = y;
        it.first_of_batch = first;
        return it;
    endfunction

    function automatic t_dir_row item_row(input pli_pkg::t_in_item it, input bit typed,
                                          input logic [31:0] y, input logic [1:0] region);
        t_dir_row r;
        r.is_cfg        = 1'b0;
        r.cfg_idx       = '0;
        r.cfg_data      = '0;
        r.item          = it;
        r.typed         = typed;
        r.want.interp_y = y;
        r.want.region   = region;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [pli_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [31:0] d);
        t_dir_row r;
        r          = item_row('0, 1'b0, '0, pli_pkg::REGION_INSIDE);
        r.is_cfg   = 1'b1;
        r.cfg_idx  = idx;
        r.cfg_data = d;
        return r;
    endfunction

    // corner values mixed with plain random ones
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic longint clamp_q(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    task automatic drive_item(input pli_pkg::t_in_item it, input bit typed,
                              input pli_pkg::t_out_item want);
        if (!quiet && $urandom_range(0, 99) < 15) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd_item <= it;
        typed_en   <= typed;
        typed_want <= want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    // sender holds off until every result is in and the block is idle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0 || busy) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pli_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send(input pli_pkg::t_in_item it);
        drive_item(it, 1'b0, '0);
    endtask

    // loads points 0..n-1, mostly sorted by x
    task automatic load_curve(input int n);
        longint x;
        bit     scrambled;
        scrambled = ($urandom_range(0, 9) == 0);
        x = longint'($signed($urandom)) >>> $urandom_range(1, 16);
        for (int i = 0; i < n; i++) begin
            send(mk_item(pli_pkg::CMD_LOAD, pli_pkg::IDX_W'(i),
                         scrambled ? pick_value() : 32'(x),
                         ($urandom_range(0, 3) == 0) ? pick_value() : $urandom, 1'b0));
            case ($urandom_range(0, 3))
                0: x = x;
                1: x = x + $urandom_range(1, 255);
                2: x = x + $urandom_range(1, 32'h0010_0000);
                default: x = x + longint'($urandom);
            endcase
            x = clamp_q(x);
        end
    endtask

    // batches of non-decreasing queries around the curve span, with some noise
    task automatic query_batches();
        longint lo, hi, q, span;
        int     n, sz;
        n  = active_points();
        lo = curve_x[0];
        hi = curve_x[n-1];
        if (hi < lo) begin
            q = lo; lo = hi; hi = q;
        end
        repeat ($urandom_range(2, 6)) begin
            sz   = $urandom_range(1, 8);
            span = hi - lo + 64;
            q    = clamp_q(lo - $urandom_range(0, 32));
            for (int i = 0; i < sz; i++) begin
                if ($urandom_range(0, 99) < 12) begin
                    if ($urandom_range(0, 2) == 0)
                        send(mk_item(pli_pkg::CMD_LOAD, pli_pkg::IDX_W'($urandom),
                                     pick_value(), pick_value(), 1'($urandom)));
                    else
                        send(mk_item(pli_pkg::CMD_QUERY, pli_pkg::IDX_W'($urandom),
                                     pick_value(), $urandom, 1'($urandom)));
                end else begin
                    send(mk_item(pli_pkg::CMD_QUERY, pli_pkg::IDX_W'($urandom), 32'(q),
                                 $urandom, i == 0));
                    if (span / sz > 64'sd4294967295)
                        q = clamp_q(q + longint'($urandom));
                    else
                        q = clamp_q(q + $urandom_range(0, 32'(span / sz + 1)));
                end
            end
        end
    endtask

    initial begin
        t_dir_row row;
        int       n;
        cycles = 0; items_sent = 0; queries_checked = 0; mismatches = 0; failures = 0;
        quiet = 1'b0;
        seg_ptr = 0; num_points = 2; use_blanking = 1'b0; blanking_value = '0;
        foreach (curve_x[i]) begin
            curve_x[i] = '0;
            curve_y[i] = '0;
        end
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cmd_item  <= '0;
        typed_en    <= 1'b0;
        typed_want  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // curve (0,0)-(1.0,2.0): midpoint, both ends, out of range both ways
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_LOAD, 0, 32'h0, 32'h0, 0), 0, 0,
                                    pli_pkg::REGION_INSIDE));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_LOAD, 1, 32'h10000, 32'h20000, 0),
                                    0, 0, pli_pkg::REGION_INSIDE));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_QUERY, 0, 32'h8000, 0, 1), 1,
                                    32'h10000, pli_pkg::REGION_INSIDE));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_QUERY, 0, 32'h8000_0000, 0, 1), 1,
                                    32'h0, pli_pkg::REGION_BELOW));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_QUERY, 0, 32'h7fff_ffff, 0, 0), 1,
                                    32'h20000, pli_pkg::REGION_ABOVE));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_QUERY, 0, 32'h0, 0, 1), 1, 32'h0,
                                    pli_pkg::REGION_INSIDE));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_QUERY, 0, 32'h10000, 0, 0), 1,
                                    32'h20000, pli_pkg::REGION_INSIDE));
        // out-of-range queries with blanking at both extremes
        dir_rows.push_back(cfg_row(pli_pkg::CFG_BLANKING_VALUE, 32'h8000_0000));
        dir_rows.push_back(cfg_row(pli_pkg::CFG_USE_BLANKING, 32'h1));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_QUERY, 0, 32'h8000_0000, 0, 1), 1,
                                    32'h8000_0000, pli_pkg::REGION_BELOW));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_QUERY, 0, 32'h7fff_ffff, 0, 0), 1,
                                    32'h8000_0000, pli_pkg::REGION_ABOVE));
        dir_rows.push_back(cfg_row(pli_pkg::CFG_BLANKING_VALUE, 32'h7fff_ffff));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_QUERY, 0, 32'hffff_0000, 0, 1), 1,
                                    32'h7fff_ffff, pli_pkg::REGION_BELOW));
        dir_rows.push_back(cfg_row(pli_pkg::CFG_USE_BLANKING, 32'h0));
        // point count below the floor clamps to two; unknown register index is ignored
        dir_rows.push_back(cfg_row(pli_pkg::CFG_NUM_POINTS, 32'h0));
        dir_rows.push_back(cfg_row(2'd3, 32'hffff_ffff));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_QUERY, 0, 32'h4000, 0, 1), 0, 0,
                                    pli_pkg::REGION_INSIDE));
        // zero-width segment gives the left y
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_LOAD, 0, 32'h5, 32'h7, 0), 0, 0,
                                    pli_pkg::REGION_INSIDE));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_LOAD, 1, 32'h5, 32'h64, 0), 0, 0,
                                    pli_pkg::REGION_INSIDE));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_QUERY, 0, 32'h5, 0, 1), 1, 32'h7,
                                    pli_pkg::REGION_INSIDE));
        // full-span segment with opposite extreme ordinates
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_LOAD, 8'hff, 32'h7fff_ffff,
                                            32'h8000_0000, 0), 0, 0, pli_pkg::REGION_INSIDE));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_LOAD, 0, 32'h8000_0000,
                                            32'h7fff_ffff, 0), 0, 0, pli_pkg::REGION_INSIDE));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_LOAD, 1, 32'h7fff_ffff,
                                            32'h8000_0000, 0), 0, 0, pli_pkg::REGION_INSIDE));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_QUERY, 0, 32'h0, 0, 1), 0, 0,
                                    pli_pkg::REGION_INSIDE));
        dir_rows.push_back(item_row(mk_item(pli_pkg::CMD_QUERY, 0, 32'h7fff_fffe, 0, 0), 0, 0,
                                    pli_pkg::REGION_INSIDE));

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                wait_idle();
                write_reg(row.cfg_idx, row.cfg_data);
            end else begin
                drive_item(row.item, row.typed, row.want);
            end
        end

        // fill the whole table once so any point count reads written entries only
        wait_idle();
        write_reg(pli_pkg::CFG_NUM_POINTS, 32'd511);
        load_curve(TABLE_DEPTH);
        query_batches();

        while (items_sent < ITEM_GOAL) begin
            quiet = (items_sent > 600 && items_sent < 800);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(2, 12);
            if ($urandom_range(0, 3) != 0) load_curve(n);
            wait_idle();
            if ($urandom_range(0, 9) < 7)
                write_reg(pli_pkg::CFG_NUM_POINTS, 32'(n));
            else
                write_reg(pli_pkg::CFG_NUM_POINTS, $urandom_range(0, 511));
            write_reg(pli_pkg::CFG_USE_BLANKING, 32'($urandom_range(0, 1)));
            write_reg(pli_pkg::CFG_BLANKING_VALUE, pick_value());
            query_batches();
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_q.size() != 0) failures++;
        $display("covered %0d beats with %0d results checked over random curves, batches,",
                 items_sent, queries_checked);
        $display("clamp and blanking settings; %0d mismatches", mismatches);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
